// File: rtl/ffba_pkg.sv
// Shared types, constants and codes of the first-fit block allocator.
package ffba_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int OFF_W      = 20;
    localparam int HDR_BYTES  = 16;

    localparam int HDR    = (HDR_BYTES + 7) & ~7;
    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int ROOM_W = OFF_W + 1;
    localparam int SZ_W   = 33;
    localparam int CMP_W  = 34;

    localparam logic [31:0]      HDR_ADDR   = 32'(HDR);
    localparam logic [SZ_W-1:0]  ALIGN_LOW  = SZ_W'(7);
    localparam logic [SZ_W-1:0]  ALIGN_MASK = ~ALIGN_LOW;
    localparam logic [CMP_W-1:0] HEAP_LIMIT = CMP_W'(1) << OFF_W;
    localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_BLOCKS);

    // Configuration register indexes.
    localparam logic REG_HEAP_START = 1'b0;
    localparam logic REG_HEAP_END   = 1'b1;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_NO_HEAP = 3'd2,
        ST_FULL    = 3'd3,
        ST_UNKNOWN = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_SCAN,
        S_HIT,
        S_FIT,
        S_CARVE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [OFF_W-1:0] size;
        logic             is_free;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [31:0] address;
        status_t     status;
    } res_t;

endpackage

// File: rtl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: config registers, sequencer, table, result register.
//
//  channel  direction  handshake            payload
//  cfg      in         cfg_we               cfg_index, cfg_wdata (heap_start, heap_end)
//  in       in         in_valid / in_stall  op, req_size, address
//  out      out        out_valid / out_stall result_address, status
//
// An item runs from acceptance to its result as follows: one entry
// of the block table is read per cycle through the table's single read port,
// newest to oldest for an allocate and oldest first for a free, then a write-back
// or two carve steps and the hand-off. Zero-size and null-free items skip the scan;
// the input opens again in the cycle after a result is handed off.
// Reset clears the block count and bump pointer; table entries are never read
// above the count, so the table needs no clearing pass.
// in_stall is high while an item is in work; the result register lets the
// next item in while a finished result waits on out_stall.
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [31:0] req_size,
    input  logic [31:0] address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_address,
    output logic [2:0]  status
);

    logic [31:0] heap_start_reg;
    logic [31:0] heap_end_reg;
    logic        out_valid_reg;
    logic [31:0] result_address_reg;
    status_t     status_reg;

    logic     busy;
    logic     in_accept;
    mem_req_t mem_req;
    entry_t   mem_rdata;
    logic     res_valid;
    logic     res_ready;
    res_t     res;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = busy;

    // Result register frees when empty or drained this cycle.
    assign res_ready = !out_valid_reg || !out_stall;

    // Configuration registers; writes must arrive only while the block is idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_start_reg <= '0;
            heap_end_reg   <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_HEAP_START)
            begin
                heap_start_reg <= cfg_wdata;
            end
            else
            begin
                heap_end_reg <= cfg_wdata;
            end
        end
    end

    // Output valid: load on a finished item, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold payload while stalled.
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            result_address_reg <= res.address;
            status_reg         <= res.status;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_address = result_address_reg;
    assign status         = status_reg;

    ffba_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_accept),
        .in_op      (op_t'(op)),
        .in_req     (req_size),
        .in_addr    (address),
        .heap_start (heap_start_reg),
        .heap_end   (heap_end_reg),
        .busy       (busy),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    ffba_ram #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (ENTRY_W),
        .AW    (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    // An accepted item keeps the input side closed on the next cycle.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall
    ) else $error("input taken again right after an accept");

    // A failed request never carries an address.
    a_fail_no_address: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> result_address == '0
    ) else $error("non-ok status with nonzero address");

    // A handed-over result shows up on the output with its address.
    a_result_loaded: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> out_valid && (result_address == $past(res.address))
    ) else $error("finished item lost on the way to the output");

endmodule

// File: rtl/ffba_ram.sv
// Single-port-write, single-port-read block table memory with registered read data.
module ffba_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 41,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/ffba_ctrl.sv
// Request sequencer: table scan, write-back, carving and the allocator counters.
module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  op_t         in_op,
    input  logic [31:0] in_req,
    input  logic [31:0] in_addr,
    input  logic [31:0] heap_start,
    input  logic [31:0] heap_end,
    output logic        busy,
    output mem_req_t    mem_req,
    input  entry_t      mem_rdata,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res
);

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [31:0]       req_reg, req_next;
    logic [31:0]       addr_reg, addr_next;
    logic [SZ_W-1:0]   sz_reg, sz_next;
    logic [31:0]       start_reg, start_next;
    logic [31:0]       diff_reg, diff_next;
    logic              under_reg, under_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ROOM_W-1:0] bump_reg, bump_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  rdidx_reg, rdidx_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    entry_t            hit_entry_reg, hit_entry_next;
    logic              heap_fail_reg, heap_fail_next;
    logic [CMP_W-1:0]  avail_reg, avail_next;
    logic [CMP_W-1:0]  total_reg, total_next;
    res_t              res_reg, res_next;

    logic             alloc_fit;
    logic             free_match;
    logic             hit;
    logic             issue;
    logic             is_zero;
    logic [CMP_W-1:0] diff_w;
    logic [CMP_W-1:0] room_w;
    logic [CMP_W-1:0] bump_w;

    assign alloc_fit  = mem_rdata.is_free && (SZ_W'(mem_rdata.size) >= sz_reg);
    assign free_match = (heap_start + 32'(mem_rdata.offset)) == start_reg;
    assign hit        = pend_reg && ((op_reg == OP_FREE) ? free_match : alloc_fit);
    assign issue      = remain_reg != '0;
    assign is_zero    = (op_reg == OP_ALLOC) ? (req_reg == '0) : (addr_reg == '0);

    // Usable heap span, capped by the offset field.
    assign diff_w = CMP_W'(diff_reg);
    assign room_w = (diff_w > HEAP_LIMIT) ? HEAP_LIMIT : diff_w;
    assign bump_w = CMP_W'(bump_reg);

    assign busy      = state_reg != S_IDLE;
    assign res_valid = state_reg == S_DONE;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            bump_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            bump_reg  <= bump_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        req_reg       <= req_next;
        addr_reg      <= addr_next;
        sz_reg        <= sz_next;
        start_reg     <= start_next;
        diff_reg      <= diff_next;
        under_reg     <= under_next;
        idx_reg       <= idx_next;
        remain_reg    <= remain_next;
        rdidx_reg     <= rdidx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_entry_reg <= hit_entry_next;
        heap_fail_reg <= heap_fail_next;
        avail_reg     <= avail_next;
        total_reg     <= total_next;
        res_reg       <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        req_next       = req_reg;
        addr_next      = addr_reg;
        sz_next        = sz_reg;
        start_next     = start_reg;
        diff_next      = diff_reg;
        under_next     = under_reg;
        count_next     = count_reg;
        bump_next      = bump_reg;
        idx_next       = idx_reg;
        remain_next    = remain_reg;
        pend_next      = pend_reg;
        rdidx_next     = rdidx_reg;
        hit_idx_next   = hit_idx_reg;
        hit_entry_next = hit_entry_reg;
        heap_fail_next = heap_fail_reg;
        avail_next     = avail_reg;
        total_next     = total_reg;
        res_next       = res_reg;
        mem_req        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = in_op;
                    req_next   = in_req;
                    addr_next  = in_addr;
                    state_next = S_CALC;
                end
            end

            S_CALC:
            begin
                sz_next     = ({1'b0, req_reg} + ALIGN_LOW) & ALIGN_MASK;
                start_next  = addr_reg - HDR_ADDR;
                diff_next   = heap_end - heap_start;
                under_next  = heap_end < heap_start;
                remain_next = count_reg;
                pend_next   = 1'b0;
                // allocate walks newest to oldest, free walks oldest up
                idx_next    = (op_reg == OP_FREE) ? '0 : IDX_W'(count_reg - CNT_W'(1));
                if (is_zero)
                begin
                    res_next.address = '0;
                    res_next.status  = ST_EMPTY;
                    state_next       = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    hit_idx_next   = rdidx_reg;
                    hit_entry_next = mem_rdata;
                    pend_next      = 1'b0;
                    state_next     = S_HIT;
                end
                else
                begin
                    mem_req.re  = issue;
                    mem_req.raddr = idx_reg;
                    pend_next   = issue;
                    rdidx_next  = idx_reg;
                    remain_next = remain_reg - CNT_W'(issue);
                    if (issue)
                    begin
                        idx_next = (op_reg == OP_FREE) ? idx_reg + IDX_W'(1)
                                                       : idx_reg - IDX_W'(1);
                    end
                    if (!issue && !pend_reg)
                    begin
                        if (op_reg == OP_FREE)
                        begin
                            res_next.address = '0;
                            res_next.status  = ST_UNKNOWN;
                            state_next       = S_DONE;
                        end
                        else
                        begin
                            state_next = S_FIT;
                        end
                    end
                end
            end

            S_HIT:
            begin
                mem_req.we              = 1'b1;
                mem_req.waddr           = hit_idx_reg;
                mem_req.wdata.offset    = hit_entry_reg.offset;
                mem_req.wdata.size      = hit_entry_reg.size;
                mem_req.wdata.is_free   = op_reg == OP_FREE;
                res_next.status         = ST_OK;
                res_next.address        = (op_reg == OP_FREE) ? '0 :
                    heap_start + 32'(hit_entry_reg.offset) + HDR_ADDR;
                state_next              = S_DONE;
            end

            S_FIT:
            begin
                heap_fail_next = under_reg || (bump_w > room_w);
                avail_next     = room_w - bump_w;
                total_next     = CMP_W'(sz_reg) + CMP_W'(HDR);
                state_next     = S_CARVE;
            end

            S_CARVE:
            begin
                res_next.address = '0;
                if (heap_fail_reg || (total_reg > avail_reg))
                begin
                    res_next.status = ST_NO_HEAP;
                end
                else if (count_reg >= CNT_MAX)
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    mem_req.we            = 1'b1;
                    mem_req.waddr         = IDX_W'(count_reg);
                    mem_req.wdata.offset  = OFF_W'(bump_reg);
                    mem_req.wdata.size    = OFF_W'(sz_reg);
                    mem_req.wdata.is_free = 1'b0;
                    count_next            = count_reg + CNT_W'(1);
                    bump_next             = ROOM_W'(bump_w + total_reg);
                    res_next.status       = ST_OK;
                    res_next.address      = heap_start + 32'(bump_reg) + HDR_ADDR;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
